>>> hw/rtl/chpt_pkg.sv
// chpt_pkg: shared types, codes and constants for the CAN heartbeat peer table
// used by chpt_front, chpt_queue, chpt_back, the top level and its checker
// no dependencies
package chpt_pkg;

  // default number of peer table slots
  localparam int PEER_SLOTS_DEF = 8;

  // front-to-back queue depth (power of two)
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);

  // own node id register
  localparam int            OWN_ID_W     = 11;
  localparam logic [10:0]   OWN_ID_RESET = 11'd1280;

  // heartbeat frame signature
  localparam logic [7:0] HB_MAGIC0 = 8'hCA;
  localparam logic [7:0] HB_MAGIC1 = 8'h4E;
  localparam logic [3:0] HB_LENGTH = 4'd8;

  // item operation codes
  localparam logic OP_FRAME   = 1'b0;
  localparam logic OP_OVERRUN = 1'b1;

  typedef logic [2:0] outcome_t;
  typedef logic [2:0] slot_t;

  // outcome codes
  localparam outcome_t OUT_NOT_HB     = 3'd0;
  localparam outcome_t OUT_OWN_HB     = 3'd1;
  localparam outcome_t OUT_UPDATED    = 3'd2;
  localparam outcome_t OUT_ADDED      = 3'd3;
  localparam outcome_t OUT_TABLE_FULL = 3'd4;
  localparam outcome_t OUT_OVERRUN    = 3'd5;

  // one input transaction
  typedef struct packed {
    logic        op;
    logic        extended_id;
    logic        remote_frame;
    logic [28:0] frame_id;
    logic [3:0]  length_code;
    logic [63:0] payload;
  } item_t;

  // one result transaction
  typedef struct packed {
    outcome_t    outcome;
    slot_t       slot;
    logic [31:0] slot_rx_count;
    logic [31:0] total_frames;
    logic [31:0] valid_heartbeats;
    logic [31:0] overrun_count;
  } result_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        is_peer;
    outcome_t    outcome;
    logic [15:0] pid;
    logic [31:0] pctr;
    logic [31:0] total;
    logic [31:0] valid_hb;
    logic [31:0] overruns;
  } entry_t;

endpackage

>>> hw/rtl/chpt_front.sv
// chpt_front: accepts transactions, classifies heartbeats, keeps the frame,
// heartbeat and overrun counters and the own node id register
// depends on chpt_pkg
module chpt_front import chpt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  item_t               item,
  input  logic                own_id_we,
  input  logic [OWN_ID_W-1:0] own_id_wdata,
  input  logic                q_full,
  output logic                busy,
  output logic                push,
  output entry_t              entry
);

  logic [OWN_ID_W-1:0] own_id;
  logic [31:0]         total;
  logic [31:0]         valid_hb;
  logic [31:0]         overruns;
  logic [31:0]         total_next;
  logic [31:0]         valid_hb_next;
  logic [31:0]         overruns_next;
  logic [15:0]         pid;
  logic                is_hb;
  logic                is_own;
  logic                accept;

  assign busy   = q_full;
  assign accept = start && !q_full;
  assign push   = accept;

  // heartbeat decode
  assign pid    = item.payload[31:16];
  assign is_hb  = (item.op == OP_FRAME) && !item.extended_id && !item.remote_frame &&
                  (item.length_code == HB_LENGTH) &&
                  (item.payload[7:0] == HB_MAGIC0) && (item.payload[15:8] == HB_MAGIC1);
  assign is_own = (pid == {{(16 - OWN_ID_W){1'b0}}, own_id});

  // counter updates for this transaction
  always_comb begin
    total_next    = total;
    valid_hb_next = valid_hb;
    overruns_next = overruns;
    if (item.op == OP_OVERRUN) begin
      overruns_next = overruns + 32'd1;
    end else begin
      total_next = total + 32'd1;
      if (is_hb && !is_own) begin
        valid_hb_next = valid_hb + 32'd1;
      end
    end
  end

  // classified entry
  always_comb begin
    entry.is_peer  = (item.op == OP_FRAME) && is_hb && !is_own;
    entry.pid      = pid;
    entry.pctr     = item.payload[63:32];
    entry.total    = total_next;
    entry.valid_hb = valid_hb_next;
    entry.overruns = overruns_next;
    if (item.op == OP_OVERRUN) begin
      entry.outcome = OUT_OVERRUN;
    end else if (is_hb && is_own) begin
      entry.outcome = OUT_OWN_HB;
    end else begin
      entry.outcome = OUT_NOT_HB;
    end
  end

  // counters and own id register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_id   <= OWN_ID_RESET;
      total    <= '0;
      valid_hb <= '0;
      overruns <= '0;
    end else begin
      if (own_id_we) begin
        own_id <= own_id_wdata;
      end
      if (accept) begin
        total    <= total_next;
        valid_hb <= valid_hb_next;
        overruns <= overruns_next;
      end
    end
  end

endmodule

>>> hw/rtl/chpt_queue.sv
// chpt_queue: short fifo of classified entries between front and back
// depends on chpt_pkg
module chpt_queue import chpt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   empty,
  output logic   full
);

  entry_t            mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign empty     = (count == '0);
  assign full      = (count == (QPTR_W + 1)'(Q_DEPTH));
  assign pop_entry = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/chpt_back.sv
// chpt_back: peer table search and update, one slot read per cycle,
// and the result register with its done strobe
// depends on chpt_pkg
module chpt_back import chpt_pkg::*; #(
  parameter int PEER_SLOTS = PEER_SLOTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  entry_t  q_entry,
  output logic    pop,
  output logic    done,
  output result_t result
);

  localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CNT_W = $clog2(PEER_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0]            state;
  entry_t                ent;
  logic [CNT_W-1:0]      rd_cnt;
  logic [IDX_W-1:0]      rd_idx;
  logic [15:0]           ident_mem [PEER_SLOTS];
  logic [31:0]           seen_mem [PEER_SLOTS];
  logic [31:0]           last_ctr_mem [PEER_SLOTS];
  logic [PEER_SLOTS-1:0] id_vld;
  logic [PEER_SLOTS-1:0] cnt_vld;
  logic [15:0]           ident_q;
  logic                  ident_vq;
  logic [31:0]           seen_q;
  logic                  seen_vq;
  logic                  cmp_en;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  hit_found;
  logic                  empty_found;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      empty_idx;
  logic [IDX_W-1:0]      sel_idx;
  logic [15:0]           eff_id;
  logic [31:0]           seen_next;

  assign rd_idx  = rd_cnt[IDX_W-1:0];
  assign pop     = (state == S_IDLE) && !q_empty;
  // a slot never written reads as empty
  assign eff_id  = ident_vq ? ident_q : 16'd0;
  assign sel_idx = hit_found ? hit_idx : empty_idx;
  assign seen_next = hit_found ? ((seen_vq ? seen_q : 32'd0) + 32'd1) : 32'd1;

  // table memories, registered reads
  always_ff @(posedge clk) begin
    ident_q  <= ident_mem[rd_idx];
    ident_vq <= id_vld[rd_idx];
    seen_q   <= seen_mem[sel_idx];
    seen_vq  <= cnt_vld[sel_idx];
    if (state == S_WRITE) begin
      seen_mem[sel_idx]     <= seen_next;
      last_ctr_mem[sel_idx] <= ent.pctr;
      if (!hit_found) begin
        ident_mem[sel_idx] <= ent.pid;
      end
    end
  end

  // sequencer, search flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      result      <= '0;
      ent         <= '0;
      rd_cnt      <= '0;
      cmp_en      <= 1'b0;
      cmp_idx     <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      hit_idx     <= '0;
      empty_idx   <= '0;
      id_vld      <= '0;
      cnt_vld     <= '0;
    end else begin
      done <= 1'b0;

      // compare stage: first matching id, first empty slot
      if (cmp_en) begin
        if (!hit_found && (eff_id == ent.pid)) begin
          hit_found <= 1'b1;
          hit_idx   <= cmp_idx;
        end
        if (!empty_found && (eff_id == 16'd0)) begin
          empty_found <= 1'b1;
          empty_idx   <= cmp_idx;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            ent <= q_entry;
            if (q_entry.is_peer) begin
              hit_found   <= 1'b0;
              empty_found <= 1'b0;
              rd_cnt      <= '0;
              state       <= S_SCAN;
            end else begin
              done                    <= 1'b1;
              result.outcome          <= q_entry.outcome;
              result.slot             <= '0;
              result.slot_rx_count    <= '0;
              result.total_frames     <= q_entry.total;
              result.valid_heartbeats <= q_entry.valid_hb;
              result.overrun_count    <= q_entry.overruns;
            end
          end
        end
        S_SCAN: begin
          cmp_en  <= 1'b1;
          cmp_idx <= rd_idx;
          rd_cnt  <= rd_cnt + 1'b1;
          if (rd_cnt == CNT_W'(PEER_SLOTS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          cmp_en <= 1'b0;
          state  <= S_LOOK;
        end
        S_LOOK: begin
          if (!hit_found && !empty_found) begin
            done                    <= 1'b1;
            result.outcome          <= OUT_TABLE_FULL;
            result.slot             <= '0;
            result.slot_rx_count    <= '0;
            result.total_frames     <= ent.total;
            result.valid_heartbeats <= ent.valid_hb;
            result.overrun_count    <= ent.overruns;
            state                   <= S_IDLE;
          end else begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          cnt_vld[sel_idx] <= 1'b1;
          if (!hit_found) begin
            id_vld[sel_idx] <= 1'b1;
          end
          done                    <= 1'b1;
          result.outcome          <= hit_found ? OUT_UPDATED : OUT_ADDED;
          result.slot             <= slot_t'(sel_idx);
          result.slot_rx_count    <= seen_next;
          result.total_frames     <= ent.total;
          result.valid_heartbeats <= ent.valid_hb;
          result.overrun_count    <= ent.overruns;
          state                   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/can_heartbeat_peer_table_unit.sv
// flow: an accepted item is written into the queue, then the back end registers its result;
//   a peer heartbeat first runs scan, drain, look and write (look ends it on a full table)
// throughput: one non-peer transaction per cycle, none while a peer heartbeat is handled;
//   a 2-entry queue lets the front accept while the back scans one table slot per cycle
// busy is high only while that queue is full; done is never held off by the receiver
// reset (synchronous, active high) clears counters, queue and table valid bits at once
module can_heartbeat_peer_table_unit import chpt_pkg::*; #(
  parameter int PEER_SLOTS = PEER_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  item_t               item,
  output logic                busy,
  input  logic                own_id_we,
  input  logic [OWN_ID_W-1:0] own_id_wdata,
  output logic                done,
  output result_t             result
);

  logic   q_push;
  logic   q_pop;
  logic   q_empty;
  logic   q_full;
  entry_t push_entry;
  entry_t pop_entry;

  // classification and counters
  chpt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .own_id_we    (own_id_we),
    .own_id_wdata (own_id_wdata),
    .q_full       (q_full),
    .busy         (busy),
    .push         (q_push),
    .entry        (push_entry)
  );

  // decoupling queue
  chpt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty),
    .full       (q_full)
  );

  // peer table
  chpt_back #(
    .PEER_SLOTS (PEER_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_entry (pop_entry),
    .pop     (q_pop),
    .done    (done),
    .result  (result)
  );

endmodule

>>> hw/rtl/chpt_checker.sv
// chpt_checker: port-level assertions for can_heartbeat_peer_table_unit,
// attached with a bind statement at the end of this file
// depends on chpt_pkg
module chpt_checker import chpt_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // after reset the unit is empty and quiet
  a_reset_quiet: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("busy or done right after reset");

  // only defined outcome codes are reported
  a_outcome_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.outcome <= OUT_OVERRUN))
    else $error("undefined outcome code");

  // no slot is reported when no slot was touched
  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    (done && (result.outcome == OUT_NOT_HB || result.outcome == OUT_OWN_HB ||
              result.outcome == OUT_TABLE_FULL || result.outcome == OUT_OVERRUN))
    |-> (result.slot == '0 && result.slot_rx_count == 32'd0))
    else $error("slot fields set for an outcome that touches no slot");

  // a newly added peer starts with a count of one
  a_added_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.outcome == OUT_ADDED) |-> (result.slot_rx_count == 32'd1))
    else $error("added peer count is not one");

endmodule

bind can_heartbeat_peer_table_unit chpt_checker u_chk (.*);
